### src/bcm_pkg.sv
// shared constants and request, result, command and status types for the block color mode unit
`default_nettype none

package bcm_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int COUNT_BITS    = 16;

   localparam int IDX_BITS  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FILL_BITS = $clog2(TABLE_ENTRIES + 1);

   typedef struct packed {
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic       last_pixel;
   } req_type;

   typedef struct packed {
      logic [7:0]  mode_red;
      logic [7:0]  mode_green;
      logic [7:0]  mode_blue;
      logic [15:0] mode_count;
      logic [5:0]  distinct_used;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic inc;
      logic append;
      logic sel_init;
      logic sel_upd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic gt;
      logic scan_end;
      logic full;
      logic last;
   } status_type;

endpackage

`default_nettype wire

### src/block_color_mode_unit.sv
// top level of the block color mode unit
//
// Pixels of one image block come in on req_data, one request per start
// pulse, taken at a clock edge where start is high and busy is low. The
// last request of a block carries last_pixel. Each pixel is looked up in
// a table of up to TABLE_ENTRIES distinct colors, one entry per cycle
// through the table memory read port; a hit ends the search early, and
// the next pixel is taken only once the search for the last one is
// through.
// After the last pixel the count memory is scanned once more to pick the
// most frequent color, first seen winning ties; the result appears on
// rsp_data with rsp_strobe high for exactly one cycle, the first cycle in
// which busy is low. The receiver cannot stall; the result must be taken
// in that cycle. The table is then empty for the next block.
// Synchronous reset empties the table and returns the sequencer to idle.
`default_nettype none

module block_color_mode_unit
   import bcm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   cmd_type    cmd;
   status_type status;

   bcm_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bcm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### src/bcm_datapath.sv
// color table, count memory, scan counter and mode selection registers
`default_nettype none

module bcm_datapath
   import bcm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_data,
   input  wire cmd_type    cmd,
   output status_type      status,
   output logic            rsp_strobe,
   output rsp_type         rsp_data
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [23:0]           table_mem [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];

   logic [23:0]           color_ff;
   logic                  last_ff;
   logic [FILL_BITS-1:0]  idx_ff, idx_in;
   logic [FILL_BITS-1:0]  cmp_idx_ff;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic [23:0]           rd_color_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;
   logic [23:0]           best_color_ff;
   logic [COUNT_BITS-1:0] best_count_ff;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;

   logic [COUNT_BITS-1:0] count_sat;
   logic [31:0]           count_wide;
   logic [31:0]           fill_wide;

   assign count_sat  = (rd_count_ff == COUNT_MAX) ? rd_count_ff : rd_count_ff + 1'b1;
   assign count_wide = 32'(best_count_ff);
   assign fill_wide  = 32'(fill_ff);

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load || cmd.sel_init) begin
         idx_in = '0;
      end else if (cmd.rd_en) begin
         idx_in = idx_ff + 1'b1;
      end
      fill_in = fill_ff;
      if (cmd.emit) begin
         fill_in = '0;
      end else if (cmd.append) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         color_ff <= {req_data.pixel_red, req_data.pixel_green, req_data.pixel_blue};
         last_ff  <= req_data.last_pixel;
      end
      if (cmd.rd_en) begin
         cmp_idx_ff <= idx_ff;
      end
      if (cmd.sel_init) begin
         best_count_ff <= '0;
      end else if (cmd.sel_upd) begin
         best_count_ff <= rd_count_ff;
         best_color_ff <= rd_color_ff;
      end
      if (cmd.emit) begin
         rsp_ff.mode_red      <= best_color_ff[23:16];
         rsp_ff.mode_green    <= best_color_ff[15:8];
         rsp_ff.mode_blue     <= best_color_ff[7:0];
         rsp_ff.mode_count    <= count_wide[15:0];
         rsp_ff.distinct_used <= fill_wide[5:0];
      end
   end

   // color table: written on append, read during scan
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         table_mem[fill_ff[IDX_BITS-1:0]] <= color_ff;
      end
      if (cmd.rd_en) begin
         rd_color_ff <= table_mem[idx_ff[IDX_BITS-1:0]];
      end
   end

   // counts: entries below the fill count are always written, so no clearing
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         count_mem[fill_ff[IDX_BITS-1:0]] <= COUNT_BITS'(1);
      end else if (cmd.inc) begin
         count_mem[cmp_idx_ff[IDX_BITS-1:0]] <= count_sat;
      end
      if (cmd.rd_en) begin
         rd_count_ff <= count_mem[idx_ff[IDX_BITS-1:0]];
      end
   end

   assign status.match    = (rd_color_ff == color_ff);
   assign status.gt       = (rd_count_ff > best_count_ff);
   assign status.scan_end = (idx_ff == fill_ff);
   assign status.full     = (fill_ff == FILL_BITS'(TABLE_ENTRIES));
   assign status.last     = last_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(TABLE_ENTRIES))
      else $error("fill count beyond table size");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held two cycles");

   a_cleared_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (fill_ff == '0))
      else $error("table not cleared after result");

   a_no_append_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !status.full)
      else $error("append into full table");

endmodule

`default_nettype wire

### src/bcm_controller.sv
// sequencer for table scan, update and mode selection
`default_nettype none

module bcm_controller
   import bcm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_SEL  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       pend_ff;
   logic       hit;

   // a compare is pending in the cycle after each memory read
   assign hit = pend_ff && status.match;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_en = !status.scan_end && !hit;
            if (hit || status.scan_end) begin
               cmd.inc    = hit;
               cmd.append = !hit && !status.full;
               if (status.last) begin
                  cmd.sel_init = 1'b1;
                  state_in     = S_SEL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SEL: begin
            cmd.rd_en   = !status.scan_end;
            cmd.sel_upd = pend_ff && status.gt;
            if (status.scan_end && !pend_ff) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= cmd.rd_en;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_inc_xor_append: assert property (@(posedge clock) disable iff (reset)
      !(cmd.inc && cmd.append))
      else $error("hit and append in one cycle");

   a_pend_not_idle: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN || state_ff == S_SEL))
      else $error("compare pending while idle");

endmodule

`default_nettype wire

### dv/block_color_mode_checker.sv
// checker that predicts and compares the block color mode results
`timescale 1ns / 100ps
`default_nettype none

module block_color_mode_checker
   import bcm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           results_due
);

   logic [23:0]           color_seen  [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] color_tally [TABLE_ENTRIES];
   int                    colors_in_use;
   rsp_type               mode_due [$];

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type     due;
      logic [23:0] rgb;
      int          hit;
      int          best;
      if (reset) begin
         colors_in_use = 0;
         mode_due.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (mode_due.size() == 0) begin
               $error("result with no block pending: %p", rsp_data);
               fail_count++;
            end else begin
               due = mode_due.pop_front();
               check_field("mode_red", due.mode_red, rsp_data.mode_red);
               check_field("mode_green", due.mode_green, rsp_data.mode_green);
               check_field("mode_blue", due.mode_blue, rsp_data.mode_blue);
               check_field("mode_count", due.mode_count, rsp_data.mode_count);
               check_field("distinct_used", due.distinct_used, rsp_data.distinct_used);
            end
         end
         if (start && busy === 1'b0) begin
            rgb = {req_data.pixel_red, req_data.pixel_green, req_data.pixel_blue};
            hit = -1;
            for (int i = 0; i < colors_in_use; i++)
               if (hit < 0 && color_seen[i] == rgb) hit = i;
            if (hit >= 0) begin
               // count sticks at all ones
               if (color_tally[hit] != '1) color_tally[hit]++;
            end else if (colors_in_use < TABLE_ENTRIES) begin
               color_seen[colors_in_use]  = rgb;
               color_tally[colors_in_use] = 1;
               colors_in_use++;
            end
            if (req_data.last_pixel) begin
               // strict compare keeps the earliest entry on ties
               best = 0;
               for (int i = 1; i < colors_in_use; i++)
                  if (color_tally[i] > color_tally[best]) best = i;
               due.mode_red      = color_seen[best][23:16];
               due.mode_green    = color_seen[best][15:8];
               due.mode_blue     = color_seen[best][7:0];
               due.mode_count    = 16'(color_tally[best]);
               due.distinct_used = 6'(colors_in_use);
               mode_due.push_back(due);
               colors_in_use = 0;
            end
         end
      end
      results_due <= mode_due.size();
   end

endmodule

`default_nettype wire

### dv/tb_block_color_mode_unit.sv
// testbench top for the block color mode unit: stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb_block_color_mode_unit;
   import bcm_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      results_due;
   bit      gaps_on;
   int      idle_cycles;

   block_color_mode_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   block_color_mode_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #6 clock = ~clock;

   // cycles with neither a request nor a result taken
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic send_pixel(input logic [23:0] rgb, input logic last);
      int gap;
      start    <= 1'b1;
      req_data <= {rgb, last};
      do @(posedge clock); while (busy !== 1'b0);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [23:0] palette [8];
      int          kind;
      int          colors;
      int          len;
      int          random_items;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      gaps_on     = 1'b1;
      idle_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single pixel blocks at both color extremes
      send_pixel(24'h000000, 1'b1);
      send_pixel(24'hFFFFFF, 1'b1);
      // tie between two colors, the first one seen wins
      send_pixel(24'h102030, 1'b0);
      send_pixel(24'hA0B0C0, 1'b0);
      send_pixel(24'hA0B0C0, 1'b0);
      send_pixel(24'h102030, 1'b1);
      // later color overtakes the first
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'hFF00FF, 1'b0);
      send_pixel(24'hFF00FF, 1'b1);
      // all distinct, counts of one
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'h0000FF, 1'b1);

      // overfill the table, then count an old entry and drop a new one
      for (int n = 0; n < TABLE_ENTRIES + 1; n++)
         send_pixel({8'(n), 8'(~n), 8'(n * 7)}, 1'b0);
      send_pixel({8'(5), 8'(~5), 8'(35)}, 1'b0);
      send_pixel({8'(5), 8'(~5), 8'(35)}, 1'b0);
      send_pixel(24'hFFFFFE, 1'b1);

      random_items = 0;
      while (random_items < 450) begin
         kind    = $urandom_range(0, 99);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (kind < 60) begin
            // few colors with many repeats
            colors = $urandom_range(1, 8);
            for (int k = 0; k < colors; k++)
               case ($urandom_range(0, 5))
                  0: palette[k] = 24'h000000;
                  1: palette[k] = 24'hFFFFFF;
                  default: palette[k] = 24'($urandom);
               endcase
            len = $urandom_range(1, 40);
            for (int n = 0; n < len; n++)
               send_pixel(palette[$urandom_range(0, colors - 1)], n == len - 1);
         end else if (kind < 80) begin
            // random colors with repeats of one, often more distinct than the table holds
            palette[0] = 24'($urandom);
            len = $urandom_range(TABLE_ENTRIES + 1, TABLE_ENTRIES + 16);
            for (int n = 0; n < len; n++)
               send_pixel((n > 0 && $urandom_range(0, 3) == 0) ? palette[0] : 24'($urandom),
                          n == len - 1);
         end else begin
            len = $urandom_range(1, 6);
            for (int n = 0; n < len; n++)
               send_pixel(24'($urandom), n == len - 1);
         end
         random_items += len;
      end
      start <= 1'b0;

      do @(posedge clock); while (results_due != 0);
      repeat (2 * TABLE_ENTRIES + 8) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
